// ----- design/bwdl_pkg.sv -----
// package: constants, widths and register codes for the window density locator
package bwdl_pkg;

  localparam int MAX_COLS_DEF     = 1024;
  localparam int MAX_ROWS_DEF     = 1024;
  localparam int MAX_WIN_ROWS_DEF = 128;

  localparam int PIX_W   = 8;
  localparam int FCOLS_W = 11;
  localparam int FROWS_W = 11;
  localparam int TOP_W   = 10;
  localparam int WCOLS_W = 11;
  localparam int WROWS_W = 8;
  localparam int THR_W   = 18;
  localparam int HCOL_W  = 10;
  localparam int HROW_W  = 11;
  localparam int CCNT_W  = 8;
  localparam int RCNT_W  = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_COLS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_ROWS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_UP   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_WHITE_LEVEL = 3'd7;

  localparam logic [FCOLS_W-1:0] RST_FRAME_COLS  = 11'd440;
  localparam logic [FROWS_W-1:0] RST_FRAME_ROWS  = 11'd804;
  localparam logic [TOP_W-1:0]   RST_BAND_TOP    = 10'd0;
  localparam logic [WCOLS_W-1:0] RST_WIN_COLS    = 11'd88;
  localparam logic [WROWS_W-1:0] RST_WIN_ROWS    = 8'd114;
  localparam logic [THR_W-1:0]   RST_THRESHOLD   = 18'd3009;
  localparam logic               RST_BOTTOM_UP   = 1'b0;
  localparam logic [PIX_W-1:0]   RST_WHITE_LEVEL = 8'd150;

endpackage

// ----- design/binary_window_density_locator.sv -----
// top level: binarized box count search over a pixel stream, memory based
//
//  channel | direction | handshake         | payload
//  in_     | input     | in_valid/in_stall | in_pixel, in_frame_start
//  out_    | output    | out_valid/out_stall | out_found, out_hit_col, out_hit_row
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one pixel per cycle while in_stall is low; a pixel passes three stages: history and column count
// memory read, column/box count update with write back, hit compare
// the column count memory is forwarded from the update stage on back to back reuse
// one result per frame, registered in out_valid_r after the last pixel request passes stages 1 and 2
// rst_n clears control; the memories need no clearing pass
// a frame's last pixel is held off only while another result is pending or stalled
module binary_window_density_locator #(
  parameter int MAX_COLS     = bwdl_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS     = bwdl_pkg::MAX_ROWS_DEF,
  parameter int MAX_WIN_ROWS = bwdl_pkg::MAX_WIN_ROWS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [bwdl_pkg::PIX_W-1:0]        in_pixel,
  input  logic                              in_frame_start,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_found,
  output logic [bwdl_pkg::HCOL_W-1:0]       out_hit_col,
  output logic [bwdl_pkg::HROW_W-1:0]       out_hit_row,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bwdl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bwdl_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CW   = $clog2(MAX_COLS);
  localparam int RW   = $clog2(MAX_ROWS);
  localparam int PHW  = $clog2(MAX_WIN_ROWS);
  localparam int CCW  = ($clog2(MAX_COLS + 1) > 11) ? $clog2(MAX_COLS + 1) + 1 : 12;
  localparam int RCW  = ($clog2(MAX_ROWS + 1) > 11) ? $clog2(MAX_ROWS + 1) + 1 : 12;
  localparam int YW   = (RW > 10) ? RW + 1 : 11;
  localparam int HW   = ($clog2(MAX_WIN_ROWS + 1) > 8) ? $clog2(MAX_WIN_ROWS + 1) + 1 : 9;
  localparam int HDEP = MAX_WIN_ROWS * MAX_COLS;
  localparam int HAW  = $clog2(HDEP);
  localparam int CCNT = bwdl_pkg::CCNT_W;
  localparam int RCNT = bwdl_pkg::RCNT_W;

  // configuration
  logic [bwdl_pkg::FCOLS_W-1:0] frame_cols_r;
  logic [bwdl_pkg::FROWS_W-1:0] frame_rows_r;
  logic [bwdl_pkg::TOP_W-1:0]   band_top_r;
  logic [bwdl_pkg::WCOLS_W-1:0] win_cols_r;
  logic [bwdl_pkg::WROWS_W-1:0] win_rows_r;
  logic [bwdl_pkg::THR_W-1:0]   thr_r;
  logic                         bottom_up_r;
  logic [bwdl_pkg::PIX_W-1:0]   white_level_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_cols_r  <= bwdl_pkg::RST_FRAME_COLS;
      frame_rows_r  <= bwdl_pkg::RST_FRAME_ROWS;
      band_top_r    <= bwdl_pkg::RST_BAND_TOP;
      win_cols_r    <= bwdl_pkg::RST_WIN_COLS;
      win_rows_r    <= bwdl_pkg::RST_WIN_ROWS;
      thr_r         <= bwdl_pkg::RST_THRESHOLD;
      bottom_up_r   <= bwdl_pkg::RST_BOTTOM_UP;
      white_level_r <= bwdl_pkg::RST_WHITE_LEVEL;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bwdl_pkg::REG_FRAME_COLS:  frame_cols_r  <= cfg_data[bwdl_pkg::FCOLS_W-1:0];
        bwdl_pkg::REG_FRAME_ROWS:  frame_rows_r  <= cfg_data[bwdl_pkg::FROWS_W-1:0];
        bwdl_pkg::REG_BAND_TOP:    band_top_r    <= cfg_data[bwdl_pkg::TOP_W-1:0];
        bwdl_pkg::REG_WIN_COLS:    win_cols_r    <= cfg_data[bwdl_pkg::WCOLS_W-1:0];
        bwdl_pkg::REG_WIN_ROWS:    win_rows_r    <= cfg_data[bwdl_pkg::WROWS_W-1:0];
        bwdl_pkg::REG_THRESHOLD:   thr_r         <= cfg_data[bwdl_pkg::THR_W-1:0];
        bwdl_pkg::REG_BOTTOM_UP:   bottom_up_r   <= cfg_data[0];
        bwdl_pkg::REG_WHITE_LEVEL: white_level_r <= cfg_data[bwdl_pkg::PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped sizes
  logic [CCW-1:0] cols_c, win_w;
  logic [RCW-1:0] rows_c;
  logic [HW-1:0]  win_h;

  always_comb begin
    cols_c = CCW'(frame_cols_r);
    if (cols_c == '0) cols_c = CCW'(1);
    if (cols_c > CCW'(MAX_COLS)) cols_c = CCW'(MAX_COLS);
    rows_c = RCW'(frame_rows_r);
    if (rows_c == '0) rows_c = RCW'(1);
    if (rows_c > RCW'(MAX_ROWS)) rows_c = RCW'(MAX_ROWS);
    win_h = HW'(win_rows_r);
    if (win_h > HW'(MAX_WIN_ROWS)) win_h = HW'(MAX_WIN_ROWS);
    win_w = CCW'(win_cols_r);
  end

  // position and stage 0
  logic [CW-1:0]  col_r, col_nxt, c0, cb0;
  logic [RW-1:0]  row_r, row_nxt, y0;
  logic [PHW-1:0] ph_r, ph_nxt, ph0;
  logic           full_r, full_nxt, full0;
  logic [HW-1:0]  ph_inc;
  logic [CCW-1:0] cx;
  logic [YW-1:0]  yx;
  logic           in_band0, depth0, cge0, clast0, last0, white0, in_acc, ph_wrap;
  logic [HAW-1:0] haddr0;
  logic [RW-1:0]  hrow0;

  logic           s1_v_r, s1_last_r, s2_v_r, s2_last_r, out_valid_r;

  always_comb begin
    c0 = (in_frame_start) ? '0 : col_r;
    if (CCW'(c0) > CCW'(MAX_COLS - 1)) c0 = CW'(MAX_COLS - 1);
    y0 = (in_frame_start) ? '0 : row_r;
    cx = CCW'(c0);
    yx = YW'(y0);
    depth0 = (yx == YW'(band_top_r));
    ph0 = depth0 ? '0 : ph_r;
    full0 = depth0 ? 1'b0 : full_r;
    in_band0 = (yx >= YW'(band_top_r)) && (win_h != '0) && (win_w != '0);
    cge0 = (cx >= win_w);
    cb0 = CW'(cx - win_w);
    white0 = (in_pixel > white_level_r);
    clast0 = (cx + CCW'(1) >= cols_c);
    last0 = clast0 && (RCW'(y0) + RCW'(1) >= rows_c);
    haddr0 = HAW'(ph0) * HAW'(MAX_COLS) + HAW'(c0);
    hrow0 = RW'(yx - YW'(win_h));
    ph_inc = HW'(ph0) + HW'(1);
    ph_wrap = (ph_inc == win_h);
  end

  assign in_stall = last0 && ((s1_v_r && s1_last_r) || (s2_v_r && s2_last_r) ||
                              (out_valid_r && out_stall));
  assign in_acc = in_valid && !in_stall;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    ph_nxt = ph_r;
    full_nxt = full_r;
    if (in_acc) begin
      if (last0) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (clast0) begin
        col_nxt = '0;
        row_nxt = y0 + RW'(1);
      end else begin
        col_nxt = c0 + CW'(1);
        row_nxt = y0;
      end
      if (in_band0 && clast0) begin
        ph_nxt = ph_wrap ? '0 : PHW'(ph_inc);
        full_nxt = full0 || ph_wrap;
      end else begin
        ph_nxt = ph0;
        full_nxt = full0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      ph_r   <= '0;
      full_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      ph_r   <= ph_nxt;
      full_r <= full_nxt;
    end
  end

  // history memory: read old bit and, inside the band, write the new one in the same request
  logic hist_mem [HDEP];
  logic hist_q;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      hist_q <= hist_mem[haddr0];
      if (in_band0) hist_mem[haddr0] <= white0;
    end
  end

  // column count memory, two read ports
  logic [CCNT-1:0] cwc_mem [MAX_COLS];
  logic [CCNT-1:0] cwc_a_q, cwc_b_q, cc1;
  logic            cwc_we;

  // stage 1 registers
  logic [CW-1:0]   s1_c_r, s1_cb_r;
  logic            s1_inb_r, s1_d0_r, s1_full_r, s1_cge_r, s1_white_r, s1_start_r;
  logic [RW-1:0]   s1_hrow_r;
  logic            byp_a_r, byp_b_r;
  logic [CCNT-1:0] byp_a_d_r, byp_b_d_r;
  logic [RCNT-1:0] rwc_r, rwc_nxt;

  assign cwc_we = s1_v_r && s1_inb_r;

  always_ff @(posedge clk) begin
    if (cwc_we) cwc_mem[s1_c_r] <= cc1;
    if (in_acc) begin
      cwc_a_q <= cwc_mem[c0];
      cwc_b_q <= cwc_mem[cb0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s1_last_r <= 1'b0;
    end else begin
      s1_v_r    <= in_acc;
      s1_last_r <= last0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_c_r     <= c0;
      s1_cb_r    <= cb0;
      s1_inb_r   <= in_band0;
      s1_d0_r    <= depth0;
      s1_full_r  <= full0;
      s1_cge_r   <= cge0;
      s1_white_r <= white0;
      s1_start_r <= in_frame_start;
      s1_hrow_r  <= hrow0;
      byp_a_r    <= cwc_we && (s1_c_r == c0);
      byp_b_r    <= cwc_we && (s1_c_r == cb0);
      byp_a_d_r  <= cc1;
      byp_b_d_r  <= cc1;
    end
  end

  logic [CCNT-1:0] cwc_a, cwc_b;

  always_comb begin
    cwc_a = byp_a_r ? byp_a_d_r : cwc_a_q;
    cwc_b = byp_b_r ? byp_b_d_r : cwc_b_q;
    if (s1_d0_r) begin
      cc1 = CCNT'(s1_white_r);
    end else begin
      cc1 = cwc_a + CCNT'(s1_white_r) - ((s1_full_r) ? CCNT'(hist_q) : '0);
    end
    rwc_nxt = ((s1_c_r == '0) ? '0 : rwc_r) + RCNT'(cc1) -
              (s1_cge_r ? RCNT'(cwc_b) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rwc_r <= '0;
    end else if (cwc_we) begin
      rwc_r <= rwc_nxt;
    end
  end

  // stage 2: compare and keep best hit
  logic [RW-1:0] s2_hrow_r;
  logic [CW-1:0] s2_hcol_r;
  logic          s2_qual_r, s2_start_r;
  logic          hit_seen_r, hit_seen_nxt, hs_base, hit2;
  logic [RW-1:0] best_row_r, best_row_nxt, br_base;
  logic [CW-1:0] best_col_r, best_col_nxt, bc_base;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r    <= 1'b0;
      s2_last_r <= 1'b0;
    end else begin
      s2_v_r    <= s1_v_r;
      s2_last_r <= s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      s2_hrow_r  <= s1_hrow_r;
      s2_hcol_r  <= s1_cb_r;
      s2_qual_r  <= s1_inb_r && s1_full_r && s1_cge_r;
      s2_start_r <= s1_start_r;
    end
  end

  always_comb begin
    hs_base = s2_start_r ? 1'b0 : hit_seen_r;
    br_base = s2_start_r ? '0 : best_row_r;
    bc_base = s2_start_r ? '0 : best_col_r;
    hit2 = s2_qual_r && (rwc_r > RCNT'(thr_r));
    hit_seen_nxt = hs_base;
    best_row_nxt = br_base;
    best_col_nxt = bc_base;
    if (hit2) begin
      if (bottom_up_r ? !(hs_base && br_base == s2_hrow_r) : !hs_base) begin
        hit_seen_nxt = 1'b1;
        best_row_nxt = s2_hrow_r;
        best_col_nxt = s2_hcol_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_seen_r <= 1'b0;
      best_row_r <= '0;
      best_col_r <= '0;
    end else if (s2_v_r) begin
      if (s2_last_r) begin
        hit_seen_r <= 1'b0;
        best_row_r <= '0;
        best_col_r <= '0;
      end else begin
        hit_seen_r <= hit_seen_nxt;
        best_row_r <= best_row_nxt;
        best_col_r <= best_col_nxt;
      end
    end
  end

  // result register
  logic                          found_r;
  logic [bwdl_pkg::HCOL_W-1:0]   hit_col_r;
  logic [bwdl_pkg::HROW_W-1:0]   hit_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_v_r && s2_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v_r && s2_last_r) begin
      found_r <= hit_seen_nxt;
      if (hit_seen_nxt) begin
        hit_col_r <= bwdl_pkg::HCOL_W'(best_col_nxt);
        hit_row_r <= bwdl_pkg::HROW_W'(best_row_nxt);
      end else begin
        hit_col_r <= '0;
        hit_row_r <= bottom_up_r ? bwdl_pkg::HROW_W'(band_top_r)
                                 : bwdl_pkg::HROW_W'(rows_c);
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_found   = found_r;
  assign out_hit_col = hit_col_r;
  assign out_hit_row = hit_row_r;

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(s2_v_r && s2_last_r && out_valid_r && out_stall))
    else $error("result overwritten while stalled");

  a_s1_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> $past(in_acc))
    else $error("stage 1 valid without request");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s2_v_r && s2_last_r))
    else $error("result without last pixel");

  a_one_last_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_v_r && s1_last_r && s2_v_r && s2_last_r))
    else $error("two frame ends in flight");
`endif

endmodule
